>>> hw/rtl/utf8_to_ucs4_decoder_assert.svh
// Assertion macros used by the decoder top-level RTL file.
`ifndef UTF8_TO_UCS4_DECODER_ASSERT_SVH
`define UTF8_TO_UCS4_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while the synchronous reset is held.
`define U2U_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("utf8_to_ucs4_decoder: assertion failed");

// Clocked assertion that is also checked during reset.
`define U2U_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("utf8_to_ucs4_decoder: assertion failed");

`else

`define U2U_ASSERT(label, clk, rst_n, prop)
`define U2U_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> hw/rtl/utf8d_pkg.sv
// Types and constants of the UTF-8 to UCS-4 decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int unsigned CP_W      = 31;
    localparam int unsigned PEND_W    = 3;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CONT_BITS = 6;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2
    } t_status;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [PEND_W-1:0] bytes_pending;
        logic [CP_W-1:0]   partial_value;
    } t_dec_state;

    // What one byte produces.
    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        t_status         status;
    } t_step_result;

endpackage

>>> hw/rtl/utf8d_step.sv
// Combinational decode of one byte against the current decoder state.
`timescale 1ns / 1ps

module utf8d_step (
    input  utf8d_pkg::t_dec_state             i_state,
    input  logic [utf8d_pkg::BYTE_W-1:0]      i_byte,
    output utf8d_pkg::t_dec_state             o_state,
    output utf8d_pkg::t_step_result           o_result
);

    logic [utf8d_pkg::CP_W-1:0] w_shifted;

    // Continuation bytes contribute their low six bits; the top two are ignored.
    assign w_shifted = {i_state.partial_value[utf8d_pkg::CP_W-utf8d_pkg::CONT_BITS-1:0],
                        i_byte[utf8d_pkg::CONT_BITS-1:0]};

    always_comb begin
        o_state             = i_state;
        o_result.emit       = 1'b0;
        o_result.code_point = '0;
        o_result.status     = utf8d_pkg::ST_OK;

        if (i_state.bytes_pending != '0) begin
            if (i_byte == '0) begin
                o_state             = '0;
                o_result.emit       = 1'b1;
                o_result.status     = utf8d_pkg::ST_TRUNC;
            end else if (i_state.bytes_pending == utf8d_pkg::PEND_W'(1)) begin
                o_state             = '0;
                o_result.emit       = 1'b1;
                o_result.code_point = w_shifted;
            end else begin
                o_state.bytes_pending = i_state.bytes_pending - utf8d_pkg::PEND_W'(1);
                o_state.partial_value = w_shifted;
            end
        end else begin
            case (i_byte) inside
                [8'h00:8'h7F]: begin
                    o_result.emit       = 1'b1;
                    o_result.code_point = utf8d_pkg::CP_W'(i_byte);
                end
                [8'hC0:8'hDF]: begin
                    o_state.bytes_pending = utf8d_pkg::PEND_W'(1);
                    o_state.partial_value = utf8d_pkg::CP_W'(i_byte[4:0]);
                end
                [8'hE0:8'hEF]: begin
                    o_state.bytes_pending = utf8d_pkg::PEND_W'(2);
                    o_state.partial_value = utf8d_pkg::CP_W'(i_byte[3:0]);
                end
                [8'hF0:8'hF7]: begin
                    o_state.bytes_pending = utf8d_pkg::PEND_W'(3);
                    o_state.partial_value = utf8d_pkg::CP_W'(i_byte[2:0]);
                end
                [8'hF8:8'hFB]: begin
                    o_state.bytes_pending = utf8d_pkg::PEND_W'(4);
                    o_state.partial_value = utf8d_pkg::CP_W'(i_byte[1:0]);
                end
                [8'hFC:8'hFD]: begin
                    o_state.bytes_pending = utf8d_pkg::PEND_W'(5);
                    o_state.partial_value = utf8d_pkg::CP_W'(i_byte[0]);
                end
                default: begin
                    // Stray continuation byte or a lead of 0xFE / 0xFF.
                    o_result.emit   = 1'b1;
                    o_result.status = utf8d_pkg::ST_INVALID;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/utf8_to_ucs4_decoder.sv
// Top level of the streaming legacy UTF-8 to UCS-4 decoder.
`timescale 1ns / 1ps
`include "utf8_to_ucs4_decoder_assert.svh"

// This block decodes a UTF-8 byte stream, including the legacy five and six
// byte forms, into 31-bit UCS-4 code points. It takes one byte per input
// transaction and gives one output transaction for every byte that completes
// a sequence, ends the text (a zero lead byte gives code point 0 with status
// ok) or is found in error; lead bytes and middle continuation bytes give no
// output. Status 1 flags a stray continuation byte or a 0xFE / 0xFF lead,
// status 2 a sequence cut short by a zero byte; both carry code point 0 and
// return the decoder to idle. The high two bits of continuation bytes are
// not checked. The block takes one byte per clock while the output is not
// stalled: a byte sits in the input register while the combinational decode
// step updates the sequence state; any result lands in the output register
// and leaves it in a cycle in which the output is not stalled. The output
// register decouples the two sides: while a result waits, one more byte can
// be taken into the input register, and the input stalls only when a byte is
// waiting there and the output register is full and stalled.

module utf8_to_ucs4_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [utf8d_pkg::BYTE_W-1:0]   i_in_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [utf8d_pkg::CP_W-1:0]     o_code_point,
    output logic [1:0]                     o_status
);

    // Input register.
    logic                           r_in_valid;
    logic [utf8d_pkg::BYTE_W-1:0]   r_in_byte;

    // Sequence state between bytes.
    utf8d_pkg::t_dec_state          r_state;
    utf8d_pkg::t_dec_state          n_state;

    // Output register.
    logic                           r_out_valid;
    logic [utf8d_pkg::CP_W-1:0]     r_out_code_point;
    utf8d_pkg::t_status             r_out_status;

    utf8d_pkg::t_step_result        w_step;
    logic                           w_out_free;
    logic                           w_advance;
    logic                           w_in_accept;

    // The output register can take a new result when it is empty or its
    // current result leaves in this cycle.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    utf8d_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_state <= n_state;
            end

            if (w_advance && w_step.emit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_byte <= i_in_byte;
        end
        if (w_advance && w_step.emit) begin
            r_out_code_point <= w_step.code_point;
            r_out_status     <= w_step.status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_out_code_point;
    assign o_status     = 2'(r_out_status);

    // The pending count never goes beyond the six-byte form.
    `U2U_ASSERT(a_pending_range, i_clk, i_rst_n,
        r_state.bytes_pending <= utf8d_pkg::PEND_W'(5))

    // Error results always carry code point zero.
    `U2U_ASSERT(a_error_zero_cp, i_clk, i_rst_n,
        (r_out_valid && r_out_status != utf8d_pkg::ST_OK) |-> (r_out_code_point == '0))

    // A byte that cannot move on stays in the input register unchanged.
    `U2U_ASSERT(a_in_hold, i_clk, i_rst_n,
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))

    // A truncation is only reported from inside a sequence.
    `U2U_ASSERT(a_trunc_in_seq, i_clk, i_rst_n,
        (w_advance && w_step.emit && w_step.status == utf8d_pkg::ST_TRUNC)
            |-> (r_state.bytes_pending != '0))

    // Reset leaves both registers empty on the next cycle.
    `U2U_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_in_valid && !r_out_valid))

endmodule
